// ===== src/stok_pkg.sv =====
`default_nettype none

package stok_pkg;

   // Default configuration
   localparam int STOK_OFFSET_BITS   = 32;
   localparam int STOK_KEYWORD_CHARS = 5;

   // Token kinds
   localparam logic [4:0] KIND_LPAREN  = 5'd0;
   localparam logic [4:0] KIND_RPAREN  = 5'd1;
   localparam logic [4:0] KIND_LBRACE  = 5'd2;
   localparam logic [4:0] KIND_RBRACE  = 5'd3;
   localparam logic [4:0] KIND_MINUS   = 5'd4;
   localparam logic [4:0] KIND_PLUS    = 5'd5;
   localparam logic [4:0] KIND_SEMI    = 5'd6;
   localparam logic [4:0] KIND_SLASH   = 5'd7;
   localparam logic [4:0] KIND_STAR    = 5'd8;
   localparam logic [4:0] KIND_NE      = 5'd9;
   localparam logic [4:0] KIND_ASSIGN  = 5'd10;
   localparam logic [4:0] KIND_EQ      = 5'd11;
   localparam logic [4:0] KIND_GT      = 5'd12;
   localparam logic [4:0] KIND_GE      = 5'd13;
   localparam logic [4:0] KIND_LT      = 5'd14;
   localparam logic [4:0] KIND_LE      = 5'd15;
   localparam logic [4:0] KIND_IDENT   = 5'd16;
   localparam logic [4:0] KIND_NUMBER  = 5'd17;
   localparam logic [4:0] KIND_INT     = 5'd18;
   localparam logic [4:0] KIND_IF      = 5'd19;
   localparam logic [4:0] KIND_ELSE    = 5'd20;
   localparam logic [4:0] KIND_WHILE   = 5'd21;
   localparam logic [4:0] KIND_PRINT   = 5'd22;
   localparam logic [4:0] KIND_EOF     = 5'd23;
   localparam logic [4:0] KIND_ERROR   = 5'd24;

   // One result item
   typedef struct packed {
      logic [4:0]  kind;
      logic [31:0] start;
      logic [31:0] length;
      logic [63:0] value;
      logic        last;
   } stok_token_type;

   // Items produced by one accepted byte, in order
   typedef struct packed {
      logic [1:0]     count;
      stok_token_type first;
      stok_token_type second;
   } stok_push_type;

endpackage

`default_nettype wire

// ===== src/source_tokenizer.sv =====
// Items of an accepted byte are registered into the result queue, then shown on rsp_ in order.
// Throughput: one byte per cycle while rsp_ready is high and each byte yields
// at most one item; a byte that yields two items can hold the next byte back. req_ready
// is set by the three-entry result queue: low while two or more items wait.
// Reset: synchronous, active high; clears scanner state and empties the queue.
`default_nettype none

module source_tokenizer
   import stok_pkg::*;
#(
   parameter int OFFSET_BITS   = STOK_OFFSET_BITS,
   parameter int KEYWORD_CHARS = STOK_KEYWORD_CHARS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_source_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [4:0]       rsp_token_kind,
   output logic [31:0]      rsp_token_start,
   output logic [31:0]      rsp_token_length,
   output logic [63:0]      rsp_number_value,
   output logic             rsp_last_of_run
);

   stok_push_type  push;
   stok_token_type head;
   logic           space;
   logic           accept;

   assign req_ready = space;
   assign accept    = req_valid && space;

   stok_scanner #(
      .OFFSET_BITS   (OFFSET_BITS),
      .KEYWORD_CHARS (KEYWORD_CHARS)
   ) u_scanner (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .source_byte (req_source_byte),
      .push        (push)
   );

   stok_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_start  = head.start;
   assign rsp_token_length = head.length;
   assign rsp_number_value = head.value;
   assign rsp_last_of_run  = head.last;

`ifndef SYNTHESIS
   a_stall_has_items: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty result queue");

   a_eof_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_source_byte == 8'd0) |=> rsp_valid)
      else $error("end of source gave no item");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_of_run) |=> rsp_valid)
      else $error("second item of a run missing");
`endif

endmodule

`default_nettype wire

// ===== src/stok_scanner.sv =====
`default_nettype none

module stok_scanner
   import stok_pkg::*;
#(
   parameter int OFFSET_BITS   = STOK_OFFSET_BITS,
   parameter int KEYWORD_CHARS = STOK_KEYWORD_CHARS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire logic [7:0]    source_byte,
   output stok_push_type      push
);

   localparam int LEN_W = $clog2(KEYWORD_CHARS + 2);
   localparam int IDX_W = $clog2(KEYWORD_CHARS);

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_NUM,
      MODE_WORD,
      MODE_BANG,
      MODE_EQ,
      MODE_LT,
      MODE_GT,
      MODE_SLASH,
      MODE_COMMENT
   } mode_type;

   mode_type                 mode_ff, mode_in;
   logic [OFFSET_BITS-1:0]   pos_ff, pos_in;
   logic [OFFSET_BITS-1:0]   begin_ff, begin_in;
   logic [63:0]              acc_ff, acc_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [7:0]               prefix_ff [KEYWORD_CHARS];

   logic                     pfx_we;
   logic [IDX_W-1:0]         pfx_idx;
   logic                     done;
   logic                     a_vld, b_vld;
   logic [4:0]               a_kind, b_kind;
   logic [OFFSET_BITS-1:0]   a_start, a_len, b_start, b_len;
   logic [63:0]              a_val;
   logic [OFFSET_BITS-1:0]   held;
   logic [4:0]               wkind;
   logic                     is_eq;
   stok_token_type           tok_a, tok_b;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
   endfunction

   // Zero-extend or truncate an offset to the 32-bit port width
   function automatic logic [31:0] to_word(input logic [OFFSET_BITS-1:0] x);
      logic [OFFSET_BITS+31:0] ext;
      ext = {32'd0, x};
      return ext[31:0];
   endfunction

   assign held  = pos_ff - begin_ff;
   assign is_eq = (source_byte == "=");

   // Classify the pending word against the keywords
   always_comb begin
      wkind = KIND_IDENT;
      case (prefix_ff[0])
         "i": begin
            if (len_ff == LEN_W'(2) && prefix_ff[1] == "f") begin
               wkind = KIND_IF;
            end else if (len_ff == LEN_W'(3) && prefix_ff[1] == "n" && prefix_ff[2] == "t") begin
               wkind = KIND_INT;
            end
         end
         "e": begin
            if (len_ff == LEN_W'(4) && prefix_ff[1] == "l" && prefix_ff[2] == "s"
                && prefix_ff[3] == "e") begin
               wkind = KIND_ELSE;
            end
         end
         "p": begin
            if (len_ff == LEN_W'(5) && prefix_ff[1] == "r" && prefix_ff[2] == "i"
                && prefix_ff[3] == "n" && prefix_ff[4] == "t") begin
               wkind = KIND_PRINT;
            end
         end
         "w": begin
            if (len_ff == LEN_W'(5) && prefix_ff[1] == "h" && prefix_ff[2] == "i"
                && prefix_ff[3] == "l" && prefix_ff[4] == "e") begin
               wkind = KIND_WHILE;
            end
         end
         default: begin
            wkind = KIND_IDENT;
         end
      endcase
   end

   // Scan one byte: extend the pending token, or close it and start a new one
   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      begin_in = begin_ff;
      acc_in   = acc_ff;
      len_in   = len_ff;
      pfx_we   = 1'b0;
      pfx_idx  = '0;
      done     = 1'b0;
      a_vld    = 1'b0;
      a_kind   = KIND_ERROR;
      a_start  = begin_ff;
      a_len    = OFFSET_BITS'(1);
      a_val    = '0;
      b_vld    = 1'b0;
      b_kind   = KIND_ERROR;
      b_start  = pos_ff;
      b_len    = OFFSET_BITS'(1);

      case (mode_ff)
         MODE_NUM: begin
            if (is_digit(source_byte)) begin
               acc_in = {acc_ff[60:0], 3'b000} + {acc_ff[62:0], 1'b0}
                        + {60'd0, source_byte[3:0]};
               done   = 1'b1;
            end else begin
               a_vld  = 1'b1;
               a_kind = KIND_NUMBER;
               a_len  = held;
               a_val  = acc_ff;
            end
         end
         MODE_WORD: begin
            if (is_alpha(source_byte) || is_digit(source_byte)) begin
               if (len_ff < LEN_W'(KEYWORD_CHARS)) begin
                  pfx_we  = 1'b1;
                  pfx_idx = len_ff[IDX_W-1:0];
               end
               if (len_ff < LEN_W'(KEYWORD_CHARS + 1)) begin
                  len_in = len_ff + LEN_W'(1);
               end
               done = 1'b1;
            end else begin
               a_vld  = 1'b1;
               a_kind = (len_ff < LEN_W'(2) || len_ff > LEN_W'(5)) ? KIND_IDENT : wkind;
               a_len  = held;
            end
         end
         MODE_BANG: begin
            a_vld  = 1'b1;
            a_kind = is_eq ? KIND_NE : KIND_ERROR;
            a_len  = is_eq ? OFFSET_BITS'(2) : OFFSET_BITS'(1);
            done   = is_eq;
         end
         MODE_EQ: begin
            a_vld  = 1'b1;
            a_kind = is_eq ? KIND_EQ : KIND_ASSIGN;
            a_len  = is_eq ? OFFSET_BITS'(2) : OFFSET_BITS'(1);
            done   = is_eq;
         end
         MODE_LT: begin
            a_vld  = 1'b1;
            a_kind = is_eq ? KIND_LE : KIND_LT;
            a_len  = is_eq ? OFFSET_BITS'(2) : OFFSET_BITS'(1);
            done   = is_eq;
         end
         MODE_GT: begin
            a_vld  = 1'b1;
            a_kind = is_eq ? KIND_GE : KIND_GT;
            a_len  = is_eq ? OFFSET_BITS'(2) : OFFSET_BITS'(1);
            done   = is_eq;
         end
         MODE_SLASH: begin
            if (source_byte == "/") begin
               mode_in = MODE_COMMENT;
               done    = 1'b1;
            end else begin
               a_vld  = 1'b1;
               a_kind = KIND_SLASH;
            end
         end
         MODE_COMMENT: begin
            if (source_byte != 8'd0) begin
               if (source_byte == 8'h0A) begin
                  mode_in = MODE_IDLE;
               end
               done = 1'b1;
            end
         end
         default: begin
            done = 1'b0;
         end
      endcase

      if (done) begin
         // byte absorbed by the pending token
         if (mode_ff == MODE_BANG || mode_ff == MODE_EQ ||
             mode_ff == MODE_LT || mode_ff == MODE_GT) begin
            mode_in = MODE_IDLE;
         end
         pos_in = pos_ff + OFFSET_BITS'(1);
      end else if (source_byte == 8'd0) begin
         // end of source: emit end of file and start afresh
         b_vld    = 1'b1;
         b_kind   = KIND_EOF;
         b_len    = '0;
         mode_in  = MODE_IDLE;
         pos_in   = '0;
         begin_in = '0;
         acc_in   = '0;
         len_in   = '0;
      end else begin
         // start a new token at this byte
         mode_in  = MODE_IDLE;
         begin_in = pos_ff;
         pos_in   = pos_ff + OFFSET_BITS'(1);
         if (is_digit(source_byte)) begin
            mode_in = MODE_NUM;
            acc_in  = {60'd0, source_byte[3:0]};
         end else if (is_alpha(source_byte)) begin
            mode_in = MODE_WORD;
            pfx_we  = 1'b1;
            pfx_idx = '0;
            len_in  = LEN_W'(1);
         end else begin
            case (source_byte)
               " ", 8'h09, 8'h0D, 8'h0A: b_vld = 1'b0;
               "(": begin b_vld = 1'b1; b_kind = KIND_LPAREN; end
               ")": begin b_vld = 1'b1; b_kind = KIND_RPAREN; end
               "{": begin b_vld = 1'b1; b_kind = KIND_LBRACE; end
               "}": begin b_vld = 1'b1; b_kind = KIND_RBRACE; end
               "-": begin b_vld = 1'b1; b_kind = KIND_MINUS; end
               "+": begin b_vld = 1'b1; b_kind = KIND_PLUS; end
               ";": begin b_vld = 1'b1; b_kind = KIND_SEMI; end
               "*": begin b_vld = 1'b1; b_kind = KIND_STAR; end
               "/": mode_in = MODE_SLASH;
               "!": mode_in = MODE_BANG;
               "=": mode_in = MODE_EQ;
               "<": mode_in = MODE_LT;
               ">": mode_in = MODE_GT;
               default: begin
                  b_vld  = 1'b1;
                  b_kind = KIND_ERROR;
               end
            endcase
         end
      end
   end

   // Pack the items in order, marking the last of the run
   always_comb begin
      tok_a.kind   = a_kind;
      tok_a.start  = to_word(a_start);
      tok_a.length = to_word(a_len);
      tok_a.value  = a_val;
      tok_a.last   = !b_vld;
      tok_b.kind   = b_kind;
      tok_b.start  = to_word(b_start);
      tok_b.length = to_word(b_len);
      tok_b.value  = '0;
      tok_b.last   = 1'b1;
      push.first   = a_vld ? tok_a : tok_b;
      push.second  = tok_b;
      push.count   = accept ? ({1'b0, a_vld} + {1'b0, b_vld}) : 2'd0;
   end

   // Hold scanner state; advance on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         begin_ff <= '0;
         acc_ff   <= '0;
         len_ff   <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         begin_ff <= begin_in;
         acc_ff   <= acc_in;
         len_ff   <= len_in;
      end
      if (accept && pfx_we) begin
         prefix_ff[pfx_idx] <= source_byte;
      end
   end

endmodule

`default_nettype wire

// ===== src/stok_queue.sv =====
`default_nettype none

module stok_queue
   import stok_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire stok_push_type push,
   output logic               space,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output stok_token_type     head
);

   stok_token_type slot_ff [3];
   stok_token_type slot_in [3];
   stok_token_type shifted [3];
   logic [1:0]     cnt_ff, cnt_in;
   logic [1:0]     base;
   logic           pop;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign space     = (cnt_ff <= 2'd1);
   assign head      = slot_ff[0];
   assign base      = cnt_ff - {1'b0, pop};
   assign cnt_in    = base + push.count;

   assign shifted[0] = slot_ff[1];
   assign shifted[1] = slot_ff[2];
   assign shifted[2] = slot_ff[2];

   // Drop the head on pop, append new items behind the survivors
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < base) begin
            slot_in[i] = pop ? shifted[i] : slot_ff[i];
         end else if (2'(i) == base && push.count != 2'd0) begin
            slot_in[i] = push.first;
         end else if (2'(i) == base + 2'd1 && push.count == 2'd2) begin
            slot_in[i] = push.second;
         end else begin
            slot_in[i] = slot_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot_ff <= slot_in;
   end

endmodule

`default_nettype wire
